>>> rtl/assert_macros.svh
// assertion macros shared by the select unit modules
// expects i_clk and i_rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

>>> rtl/uvrls_pkg.sv
// shared types, codes and constants of the uv region / lasso select unit
// no dependencies
`timescale 1ns / 1ps

package uvrls_pkg;

    // coordinate format, signed fixed point with 16 fraction bits
    localparam int COORD_W = 32;
    localparam int TAG_W = 24;
    localparam int MAX_VERT_DEF = 64;
    localparam int MIN_POLY_VERT = 3;

    // configuration port
    localparam int APB_DW = 32;
    localparam int ADDR_W = 5;
    localparam int REG_IDX_W = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_SELECT_MODE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CORNER_A_U = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CORNER_A_V = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CORNER_B_U = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CORNER_B_V = 3'd4;

    // operation codes of an input transaction
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEST = 2'd2;

    // select modes
    localparam logic MODE_REGION = 1'b0;
    localparam logic MODE_LASSO = 1'b1;

    typedef struct packed {
        logic                      select_mode;
        logic signed [COORD_W-1:0] corner_a_u;
        logic signed [COORD_W-1:0] corner_a_v;
        logic signed [COORD_W-1:0] corner_b_u;
        logic signed [COORD_W-1:0] corner_b_v;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic start_test;
        logic rd_en;
        logic rd_prime;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic busy;
        logic poly_ok;
    } t_dp_sts;

endpackage

>>> rtl/uvrls_if.sv
// valid/ready channel interfaces for the select unit input and result streams
// depends on uvrls_pkg
`timescale 1ns / 1ps

interface uvrls_in_if
    import uvrls_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic signed [COORD_W-1:0] coord_u;
    logic signed [COORD_W-1:0] coord_v;
    logic [TAG_W-1:0]          point_tag;

    modport source (output valid, opcode, coord_u, coord_v, point_tag, input ready);
    modport sink (input valid, opcode, coord_u, coord_v, point_tag, output ready);
endinterface

interface uvrls_out_if
    import uvrls_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [TAG_W-1:0] tag_out;
    logic             contained;
    logic             on_boundary;
    logic             overflow_seen;

    modport source (output valid, tag_out, contained, on_boundary, overflow_seen, input ready);
    modport sink (input valid, tag_out, contained, on_boundary, overflow_seen, output ready);
endinterface

>>> rtl/uvrls_dp.sv
// datapath: polygon vertex memory, edge pipeline, box test and result registers
// depends on uvrls_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uvrls_dp
    import uvrls_pkg::*;
#(
    parameter int MAX_VERT = MAX_VERT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_dp_cmd                             i_cmd,
    input  logic [$clog2(MAX_VERT)-1:0]         i_rd_addr,
    input  t_cfg                                i_cfg,
    input  logic signed [COORD_W-1:0]           i_coord_u,
    input  logic signed [COORD_W-1:0]           i_coord_v,
    input  logic [TAG_W-1:0]                    i_point_tag,
    output t_dp_sts                             o_sts,
    output logic [$clog2(MAX_VERT+1)-1:0]       o_count,
    output logic [TAG_W-1:0]                    o_tag_out,
    output logic                                o_contained,
    output logic                                o_on_boundary,
    output logic                                o_overflow_seen
);

    localparam int AW = $clog2(MAX_VERT);
    localparam int CNTW = $clog2(MAX_VERT + 1);
    localparam int DW = COORD_W + 1;
    localparam int PW = 2 * DW;

    // vertex memory
    logic signed [COORD_W-1:0] r_mem_u [MAX_VERT];
    logic signed [COORD_W-1:0] r_mem_v [MAX_VERT];

    logic [CNTW-1:0] r_count;
    logic            r_overflow;
    logic            can_append;

    // tested point
    logic signed [COORD_W-1:0] r_pu;
    logic signed [COORD_W-1:0] r_pv;
    logic [TAG_W-1:0]          r_tag;

    // stage 0: vertex read from memory, previous vertex held as q
    logic                      r_s0_vld;
    logic                      r_s0_prime;
    logic signed [COORD_W-1:0] r_cu;
    logic signed [COORD_W-1:0] r_cv;
    logic signed [COORD_W-1:0] r_qu;
    logic signed [COORD_W-1:0] r_qv;

    // stage 1: differences and compare flags
    logic                 r_s1_vld;
    logic signed [DW-1:0] r_d_pvq;
    logic signed [DW-1:0] r_d_cuq;
    logic signed [DW-1:0] r_d_puq;
    logic signed [DW-1:0] r_d_cvq;
    logic                 r_s1_bbox;
    logic                 r_s1_cross;
    logic                 r_s1_dpos;
    logic                 n_bbox;
    logic                 n_cross;
    logic                 n_dpos;

    // stage 2: cross products
    logic                 r_s2_vld;
    logic signed [PW-1:0] r_prod_a;
    logic signed [PW-1:0] r_prod_b;
    logic                 r_s2_bbox;
    logic                 r_s2_cross;
    logic                 r_s2_dpos;

    // walk accumulators
    logic r_edge_hit;
    logic r_inside;
    logic flip;

    // result registers
    logic             r_out_contained;
    logic             r_out_on_boundary;
    logic             r_out_overflow;
    logic [TAG_W-1:0] r_out_tag;
    logic             box_hit;

    assign can_append = (r_count < CNTW'(MAX_VERT));

    // vertex count and sticky overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_overflow <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_overflow <= 1'b0;
        end else if (i_cmd.append) begin
            if (can_append) begin
                r_count <= CNTW'(r_count + 1'b1);
            end else begin
                r_overflow <= 1'b1;
            end
        end
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && can_append) begin
            r_mem_u[r_count[AW-1:0]] <= i_coord_u;
            r_mem_v[r_count[AW-1:0]] <= i_coord_v;
        end
        if (i_cmd.rd_en) begin
            r_cu <= r_mem_u[i_rd_addr];
            r_cv <= r_mem_v[i_rd_addr];
        end
    end

    // point capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_test) begin
            r_pu <= i_coord_u;
            r_pv <= i_coord_v;
            r_tag <= i_point_tag;
        end
    end

    // pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s0_prime <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s0_vld <= i_cmd.rd_en;
            r_s0_prime <= i_cmd.rd_prime;
            r_s1_vld <= r_s0_vld && !r_s0_prime;
            r_s2_vld <= r_s1_vld;
        end
    end

    // edge from q to c: inclusive bounding box and ray crossing flags
    assign n_bbox = (r_qu <= r_pu || r_cu <= r_pu) && (r_pu <= r_qu || r_pu <= r_cu)
                 && (r_qv <= r_pv || r_cv <= r_pv) && (r_pv <= r_qv || r_pv <= r_cv);
    assign n_cross = (r_cv > r_pv) != (r_qv > r_pv);
    assign n_dpos = (r_qv > r_cv);

    // stage 1 registers and previous vertex
    always_ff @(posedge i_clk) begin
        if (r_s0_vld) begin
            r_qu <= r_cu;
            r_qv <= r_cv;
            r_d_pvq <= DW'(r_pv) - DW'(r_qv);
            r_d_cuq <= DW'(r_cu) - DW'(r_qu);
            r_d_puq <= DW'(r_pu) - DW'(r_qu);
            r_d_cvq <= DW'(r_cv) - DW'(r_qv);
            r_s1_bbox <= n_bbox;
            r_s1_cross <= n_cross;
            r_s1_dpos <= n_dpos;
        end
    end

    // stage 2: one orientation product pair serves both the edge and crossing tests
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_prod_a <= PW'(r_d_pvq) * PW'(r_d_cuq);
            r_prod_b <= PW'(r_d_puq) * PW'(r_d_cvq);
            r_s2_bbox <= r_s1_bbox;
            r_s2_cross <= r_s1_cross;
            r_s2_dpos <= r_s1_dpos;
        end
    end

    // crossing at or to the right of the point flips the parity
    assign flip = r_s2_cross && (r_s2_dpos ? (r_prod_a <= r_prod_b) : (r_prod_a >= r_prod_b));

    // accumulate on-edge hit and even-odd parity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_hit <= 1'b0;
            r_inside <= 1'b0;
        end else if (i_cmd.start_test) begin
            r_edge_hit <= 1'b0;
            r_inside <= 1'b0;
        end else if (r_s2_vld) begin
            if (r_prod_a == r_prod_b && r_s2_bbox) begin
                r_edge_hit <= 1'b1;
            end
            if (flip) begin
                r_inside <= !r_inside;
            end
        end
    end

    // inclusive box test, corners in either order
    assign box_hit = (i_cfg.corner_a_u <= r_pu || i_cfg.corner_b_u <= r_pu)
                  && (r_pu <= i_cfg.corner_a_u || r_pu <= i_cfg.corner_b_u)
                  && (i_cfg.corner_a_v <= r_pv || i_cfg.corner_b_v <= r_pv)
                  && (r_pv <= i_cfg.corner_a_v || r_pv <= i_cfg.corner_b_v);

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_tag <= r_tag;
            r_out_overflow <= r_overflow;
            if (i_cfg.select_mode == MODE_LASSO) begin
                r_out_contained <= r_edge_hit || r_inside;
                r_out_on_boundary <= r_edge_hit;
            end else begin
                r_out_contained <= box_hit;
                r_out_on_boundary <= 1'b0;
            end
        end
    end

    assign o_sts.busy = r_s0_vld || r_s1_vld || r_s2_vld;
    assign o_sts.poly_ok = (r_count >= CNTW'(MIN_POLY_VERT));
    assign o_count = r_count;
    assign o_tag_out = r_out_tag;
    assign o_contained = r_out_contained;
    assign o_on_boundary = r_out_on_boundary;
    assign o_overflow_seen = r_out_overflow;

    // assertions
    `ASSERT_ALWAYS(a_count_in_range, r_count <= CNTW'(MAX_VERT), "vertex count above capacity")
    `ASSERT_IMPLY(a_no_walk_on_update, i_cmd.clear || i_cmd.append, !o_sts.busy,
        "polygon changed while an edge walk is in flight")

endmodule

>>> rtl/uvrls_ctrl.sv
// controller: accepts transactions, sequences the edge walk, hands off results
// depends on uvrls_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uvrls_ctrl
    import uvrls_pkg::*;
#(
    parameter int MAX_VERT = MAX_VERT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [1:0]                    i_opcode,
    input  logic                          i_mode,
    input  logic                          i_out_ready,
    input  t_dp_sts                       i_sts,
    input  logic [$clog2(MAX_VERT+1)-1:0] i_count,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    output t_dp_cmd                       o_cmd,
    output logic [$clog2(MAX_VERT)-1:0]   o_rd_addr
);

    localparam int AW = $clog2(MAX_VERT);
    localparam int CNTW = $clog2(MAX_VERT + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state          r_state;
    logic [CNTW-1:0] r_walk;
    logic            r_out_valid;
    logic            accept;
    logic [CNTW-1:0] cnt_m1;
    logic [CNTW-1:0] walk_m1;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept = i_in_valid && o_in_ready;
    assign cnt_m1 = CNTW'(i_count - 1'b1);
    assign walk_m1 = CNTW'(r_walk - 1'b1);

    // commands to the datapath
    always_comb begin
        o_cmd.clear = accept && (i_opcode == OP_CLEAR);
        o_cmd.append = accept && (i_opcode == OP_APPEND);
        o_cmd.start_test = accept && (i_opcode == OP_TEST);
        o_cmd.rd_en = (r_state == ST_WALK);
        o_cmd.rd_prime = (r_state == ST_WALK) && (r_walk == '0);
        o_cmd.load_out = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);
        o_rd_addr = (r_walk == '0) ? cnt_m1[AW-1:0] : walk_m1[AW-1:0];
    end

    // state, walk counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_walk <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd.start_test) begin
                        r_walk <= '0;
                        if (i_mode == MODE_LASSO && i_sts.poly_ok) begin
                            r_state <= ST_WALK;
                        end else begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                // first read primes the closing edge vertex, then one edge per cycle
                ST_WALK: begin
                    if (r_walk == i_count) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_walk <= CNTW'(r_walk + 1'b1);
                    end
                end
                ST_DRAIN: begin
                    if (!i_sts.busy) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (o_cmd.load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

    // assertions
    `ASSERT_IMPLY(a_rd_addr_in_poly, o_cmd.rd_en, CNTW'(o_rd_addr) < i_count,
        "walk reads beyond the stored polygon")
    `ASSERT_IMPLY(a_walk_needs_poly, r_state == ST_WALK, i_sts.poly_ok && i_mode == MODE_LASSO,
        "edge walk without a valid lasso")
    `ASSERT_IMPLY(a_finish_after_drain, r_state == ST_FINISH, !i_sts.busy,
        "result taken while edge pipeline still busy")

endmodule

>>> rtl/uv_region_lasso_select_unit.sv
// top level of the uv region / lasso select unit: configuration registers,
// controller and datapath; depends on uvrls_pkg, uvrls_if, uvrls_ctrl, uvrls_dp
//
// usage: the input channel carries transactions of opcode clear, append vertex
// or test point. clear and append give no result; an append beyond capacity
// drops the vertex and sets the sticky overflow flag. a test point gives one
// result transaction on the output channel. region mode: the accepted test
// goes straight to the finish state, where the result is loaded into the
// output register and becomes valid. lasso mode with n stored vertices (n of
// three or more): the vertex memory read port is walked once per vertex plus
// one priming read, followed by three pipeline stages that drain before the
// result is loaded. fewer than three vertices answers without a walk. one
// item is in work at a time; the input is ready again right after the result
// is loaded into the output register. a stalled receiver holds the result in
// the output register; clear and append transactions still go through, a
// following test waits to finish. reset empties the polygon, clears overflow,
// configuration and control state. the user must see that the APB port is
// written only while no transaction is in work; the block does not enforce it.
`timescale 1ns / 1ps

module uv_region_lasso_select_unit
    import uvrls_pkg::*;
#(
    parameter int MAX_POLY_VERTICES = MAX_VERT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    uvrls_in_if.sink          i_in,
    uvrls_out_if.source       o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int AW = $clog2(MAX_POLY_VERTICES);
    localparam int CNTW = $clog2(MAX_POLY_VERTICES + 1);

    t_cfg                 r_cfg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    t_dp_cmd              cmd;
    t_dp_sts              sts;
    logic [AW-1:0]        rd_addr;
    logic [CNTW-1:0]      count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SELECT_MODE: r_cfg.select_mode <= pwdata[0];
                REG_CORNER_A_U:  r_cfg.corner_a_u <= pwdata[COORD_W-1:0];
                REG_CORNER_A_V:  r_cfg.corner_a_v <= pwdata[COORD_W-1:0];
                REG_CORNER_B_U:  r_cfg.corner_b_u <= pwdata[COORD_W-1:0];
                REG_CORNER_B_V:  r_cfg.corner_b_v <= pwdata[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_SELECT_MODE: prdata = APB_DW'(r_cfg.select_mode);
            REG_CORNER_A_U:  prdata = APB_DW'(r_cfg.corner_a_u);
            REG_CORNER_A_V:  prdata = APB_DW'(r_cfg.corner_a_v);
            REG_CORNER_B_U:  prdata = APB_DW'(r_cfg.corner_b_u);
            REG_CORNER_B_V:  prdata = APB_DW'(r_cfg.corner_b_v);
            default:         prdata = '0;
        endcase
    end

    // controller
    uvrls_ctrl #(
        .MAX_VERT (MAX_POLY_VERTICES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_opcode    (i_in.opcode),
        .i_mode      (r_cfg.select_mode),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .i_count     (count),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr)
    );

    // datapath
    uvrls_dp #(
        .MAX_VERT (MAX_POLY_VERTICES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_rd_addr       (rd_addr),
        .i_cfg           (r_cfg),
        .i_coord_u       (i_in.coord_u),
        .i_coord_v       (i_in.coord_v),
        .i_point_tag     (i_in.point_tag),
        .o_sts           (sts),
        .o_count         (count),
        .o_tag_out       (o_out.tag_out),
        .o_contained     (o_out.contained),
        .o_on_boundary   (o_out.on_boundary),
        .o_overflow_seen (o_out.overflow_seen)
    );

endmodule
